@@ src/uecp_pkg.sv @@
// ----------------------------------------------------------------------------
// uecp_pkg
// Shared types, constants and helper functions for the escape decoder.
// ----------------------------------------------------------------------------
package uecp_pkg;

  // Command queue geometry
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_U         = 8'd117;

  // Code point mapping constants
  localparam logic [15:0] CP_IO_UPPER   = 16'd1025;
  localparam logic [15:0] CP_IO_LOWER   = 16'd1105;
  localparam logic [15:0] CP_SPLIT      = 16'd1088;
  localparam logic [15:0] CP_OFS_LOW    = 16'd912;
  localparam logic [15:0] CP_OFS_HIGH   = 16'd864;
  localparam logic [7:0]  CP866_IO_UPPER = 8'd240;
  localparam logic [7:0]  CP866_IO_LOWER = 8'd241;

  // Escape body length in hex digits
  localparam logic [2:0] BODY_LEN = 3'd4;

  // Parser phase
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_HELD  = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  // Work handed from the parser to the output side
  typedef enum logic [1:0] {
    OP_PASS    = 2'd0,  // emit data byte
    OP_BS_PASS = 2'd1,  // emit backslash, then data byte
    OP_MAP     = 2'd2   // emit mapped code point
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] data;
    logic        last;
  } cmd_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(logic [7:0] b);
    logic [4:0] res;
    res = 5'd0;
    if (b >= 8'd48 && b <= 8'd57) begin
      res = {1'b1, 4'(b - 8'd48)};
    end else if (b >= 8'd97 && b <= 8'd102) begin
      res = {1'b1, 4'(b - 8'd87)};
    end else if (b >= 8'd65 && b <= 8'd70) begin
      res = {1'b1, 4'(b - 8'd55)};
    end
    return res;
  endfunction

  // Map a code point to its CP866 byte
  function automatic logic [7:0] map_cp866(logic [15:0] c);
    logic [15:0] diff;
    logic [7:0]  res;
    if (c < CP_SPLIT) begin
      diff = c - CP_OFS_LOW;
    end else begin
      diff = c - CP_OFS_HIGH;
    end
    res = diff[7:0];
    if (c == CP_IO_UPPER) begin
      res = CP866_IO_UPPER;
    end else if (c == CP_IO_LOWER) begin
      res = CP866_IO_LOWER;
    end
    return res;
  endfunction

endpackage

@@ src/unicode_escape_to_cp866_unit.sv @@
// ----------------------------------------------------------------------------
// unicode_escape_to_cp866_unit
// Streaming decoder of \uXXXX escapes into single CP866 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive in_byte/in_last with push high; the beat is
//   taken at a rising edge where full is low. in_last marks the final byte
//   of a string; the parser returns to plain text after it.
//   Result side is a queue: while empty is low, out_byte/out_last hold the
//   oldest result; raise pop to take it. out_last marks the final result.
//   Each input byte yields zero, one or two results: plain bytes pass,
//   a backslash is held one byte, an escape body yields one mapped byte.
// Path: the command for a result is written to the command queue, then
//   loaded into the output register, where the result becomes visible.
// Throughput: one input byte per cycle while full is low. Results leave at
//   one per cycle; a held backslash before an ordinary byte yields two beats.
//   A four-entry command queue decouples parser and output stage.
// Reset: rst_n low at a clock edge empties the queue and output register
//   and returns the parser to plain text.
// Stalls: with pop low the output holds; the queue fills and then full
//   rises, holding off the sender until results drain.
// ----------------------------------------------------------------------------
module unicode_escape_to_cp866_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import uecp_pkg::*;

  logic acc;
  logic cmd_push;
  cmd_t cmd_wr;
  cmd_t cmd_rd;
  logic q_full, q_empty, q_pop;

  assign full = q_full;
  assign acc  = push && !q_full;

  // Parse input bytes
  uecp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .byte_i   (in_byte),
    .last_i   (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd_wr)
  );

  // Buffer commands
  uecp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd_wr),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (cmd_rd),
    .q_empty (q_empty)
  );

  // Emit results
  uecp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (cmd_rd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .byte_o  (out_byte),
    .last_o  (out_last),
    .empty_o (empty),
    .pop_i   (pop)
  );

endmodule

@@ src/uecp_front.sv @@
// ----------------------------------------------------------------------------
// uecp_front
// Byte parser: tracks backslash and escape body state, issues one command
// per byte that yields output.
// ----------------------------------------------------------------------------
module uecp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          cmd_push,
  output uecp_pkg::cmd_t cmd
);
  import uecp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [15:0] code_r, code_nxt;
  logic        stop_r, stop_nxt;

  logic [4:0]  hex;
  logic [15:0] code_body;
  logic        stop_body;
  logic [2:0]  count_body;
  logic        body_done;

  // Collect one escape body byte
  always_comb begin
    hex        = hex_decode(byte_i);
    code_body  = (!stop_r && hex[4]) ? {code_r[11:0], hex[3:0]} : code_r;
    stop_body  = stop_r | ~hex[4];
    count_body = count_r + 3'd1;
    body_done  = last_i || (count_body >= BODY_LEN);
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    code_nxt  = code_r;
    stop_nxt  = stop_r;
    if (acc) begin
      phase_nxt = PH_PLAIN;
      count_nxt = 3'd0;
      code_nxt  = 16'd0;
      stop_nxt  = 1'b0;
      case (phase_r)
        PH_HELD: begin
          if (byte_i == CH_U && !last_i) begin
            phase_nxt = PH_BODY;
          end else if (byte_i == CH_BACKSLASH && !last_i) begin
            phase_nxt = PH_HELD;
          end
        end
        PH_BODY: begin
          if (!body_done) begin
            phase_nxt = PH_BODY;
            count_nxt = count_body;
            code_nxt  = code_body;
            stop_nxt  = stop_body;
          end
        end
        default: begin
          if (byte_i == CH_BACKSLASH && !last_i) begin
            phase_nxt = PH_HELD;
          end
        end
      endcase
    end
  end

  // Command output
  always_comb begin
    cmd_push  = 1'b0;
    cmd.op    = OP_PASS;
    cmd.data  = {8'd0, byte_i};
    cmd.last  = last_i;
    case (phase_r)
      PH_HELD: begin
        if (byte_i == CH_U) begin
          // lone "\u" at the end converts zero
          cmd_push = acc && last_i;
          cmd.op   = OP_MAP;
          cmd.data = 16'd0;
        end else if (byte_i == CH_BACKSLASH && !last_i) begin
          cmd_push = acc;
          cmd.data = {8'd0, CH_BACKSLASH};
          cmd.last = 1'b0;
        end else begin
          cmd_push = acc;
          cmd.op   = OP_BS_PASS;
        end
      end
      PH_BODY: begin
        cmd_push = acc && body_done;
        cmd.op   = OP_MAP;
        cmd.data = code_body;
      end
      default: begin
        cmd_push = acc && !(byte_i == CH_BACKSLASH && !last_i);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      count_r <= 3'd0;
      code_r  <= 16'd0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      code_r  <= code_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // Digit count stays within the body outside of the body phase it is zero
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < BODY_LEN)
    else $error("escape digit count out of range");

  a_plain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_BODY) |-> (count_r == 3'd0 && code_r == 16'd0 && !stop_r))
    else $error("escape state not cleared outside body");

  a_last_returns_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_i) |=> (phase_r == PH_PLAIN))
    else $error("parser not back to plain text after final byte");

endmodule

@@ src/uecp_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// uecp_cmd_fifo
// Short command queue between parser and output stage.
// ----------------------------------------------------------------------------
module uecp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  uecp_pkg::cmd_t wr_cmd,
  output logic           q_full,
  input  logic           rd_en,
  output uecp_pkg::cmd_t rd_cmd,
  output logic           q_empty
);
  import uecp_pkg::*;

  cmd_t            mem [QDepth];
  logic [QAw-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAw:0]    cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == (QAw+1)'(QDepth));
  assign q_empty = (cnt_r == '0);
  assign rd_cmd  = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    do_wr      = wr_en && !q_full;
    do_rd      = rd_en && !q_empty;
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAw+1)'(QDepth))
    else $error("command queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[QAw-1:0])
    else $error("queue pointers disagree with occupancy");

endmodule

@@ src/uecp_back.sv @@
// ----------------------------------------------------------------------------
// uecp_back
// Output stage: executes queued commands, maps code points and presents
// result beats, splitting held-backslash commands into two beats.
// ----------------------------------------------------------------------------
module uecp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  uecp_pkg::cmd_t q_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  output logic [7:0]     byte_o,
  output logic           last_o,
  output logic           empty_o,
  input  logic           pop_i
);
  import uecp_pkg::*;

  cmd_t cmd_r, cmd_nxt;
  logic valid_r, valid_nxt;
  logic step_r, step_nxt;
  logic fire, finish, load;

  // Drive the current beat
  always_comb begin
    case (cmd_r.op)
      OP_BS_PASS: begin
        byte_o = step_r ? cmd_r.data[7:0] : CH_BACKSLASH;
        last_o = step_r & cmd_r.last;
      end
      OP_MAP: begin
        byte_o = map_cp866(cmd_r.data);
        last_o = cmd_r.last;
      end
      default: begin
        byte_o = cmd_r.data[7:0];
        last_o = cmd_r.last;
      end
    endcase
  end

  assign empty_o = !valid_r;

  // Advance to the next beat or command
  always_comb begin
    fire      = pop_i && valid_r;
    finish    = fire && ((cmd_r.op != OP_BS_PASS) || step_r);
    load      = !valid_r || finish;
    q_pop     = load && !q_empty;
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    if (load) begin
      valid_nxt = !q_empty;
      cmd_nxt   = q_cmd;
      step_nxt  = 1'b0;
    end else if (fire) begin
      step_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  a_step_only_split: assert property (@(posedge clk) disable iff (!rst_n)
    step_r |-> (valid_r && cmd_r.op == OP_BS_PASS))
    else $error("second beat on a single-beat command");

  a_split_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && cmd_r.op == OP_BS_PASS && !step_r) |-> !last_o)
    else $error("held backslash marked as final beat");

endmodule
